[rtl/core/i2cmbs_pkg.sv]
`default_nettype none

package i2cmbs_pkg;

   localparam int NUM_BUSES = 2;

   typedef enum logic [2:0] {
      CMD_INIT  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4,
      CMD_TICK  = 3'd5,
      CMD_IDLE  = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_STUCK    = 2'd1,
      STATUS_REJECTED = 2'd2
   } status_type;

   // ticks each command waits for
   localparam logic [4:0] TICKS_INIT  = 5'd2;
   localparam logic [4:0] TICKS_START = 5'd2;
   localparam logic [4:0] TICKS_STOP  = 5'd3;
   localparam logic [4:0] TICKS_WRITE = 5'd18;
   localparam logic [4:0] TICKS_READ  = 5'd19;

   typedef struct packed {
      status_type              status;
      logic                    acked;
      logic [7:0]              read_data;
      logic                    done_res;
      logic                    busy_res;
      logic [NUM_BUSES-1:0]    sda_pulls;
      logic [NUM_BUSES-1:0]    scl_lines;
   } result_type;

endpackage

`default_nettype wire

[rtl/core/i2c_master_byte_sequencer_unit.sv]
// A result is registered in the output register, or in the skid entry while the
// output register holds an unread result. One request is taken per cycle while
// req_tready is high; a two-entry output stage (register plus skid) decouples rsp stalls.
// req_tready drops only while both output entries are full or reset is high.
// Reset (synchronous, active high): SCL released high, SDA released, sequencer
// idle, output stage empty.
`default_nettype none

module i2c_master_byte_sequencer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // bus, write_data[7:0], send_ack, sda_level, zero pad
   input  wire logic [2:0]  req_tuser,  // command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata   // scl_lines[1:0], sda_pulls[1:0], busy_res, done_res,
                                        // read_data[7:0], acked, status[1:0], zero pad
);

   localparam int NB = i2cmbs_pkg::NUM_BUSES;

   logic [NB-1:0]         scl_ff, scl_in;
   logic [NB-1:0]         pull_ff, pull_in;
   i2cmbs_pkg::cmd_type   active_ff, active_in;
   logic                  bus_ff, bus_in;
   logic [4:0]            step_ff, step_in;
   logic [7:0]            shift_ff, shift_in;
   logic                  ackreq_ff, ackreq_in;

   i2cmbs_pkg::result_type out_ff, skid_ff, res;
   logic                   out_valid_ff, skid_valid_ff;

   logic                 accept, pop;
   i2cmbs_pkg::cmd_type  cmd;
   logic                 req_bus, req_ack, req_sda;
   logic [7:0]           req_wdata;
   logic                 busy;
   logic [4:0]           t;
   logic [4:0]           total;
   logic [NB-1:0]        m;
   logic                 done, acked;
   logic [7:0]           rdata;
   i2cmbs_pkg::status_type status;

   assign cmd       = i2cmbs_pkg::cmd_type'(req_tuser);
   assign req_bus   = req_tdata[0];
   assign req_wdata = req_tdata[8:1];
   assign req_ack   = req_tdata[9];
   assign req_sda   = req_tdata[10];

   assign req_tready = !skid_valid_ff && !reset;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;
   assign busy       = active_ff != i2cmbs_pkg::CMD_IDLE;
   assign t          = step_ff + 5'd1;

   always_comb begin
      case (active_ff)
         i2cmbs_pkg::CMD_INIT:  total = i2cmbs_pkg::TICKS_INIT;
         i2cmbs_pkg::CMD_START: total = i2cmbs_pkg::TICKS_START;
         i2cmbs_pkg::CMD_STOP:  total = i2cmbs_pkg::TICKS_STOP;
         i2cmbs_pkg::CMD_WRITE: total = i2cmbs_pkg::TICKS_WRITE;
         default:               total = i2cmbs_pkg::TICKS_READ;
      endcase
   end

   always_comb begin
      scl_in    = scl_ff;
      pull_in   = pull_ff;
      active_in = active_ff;
      bus_in    = bus_ff;
      step_in   = step_ff;
      shift_in  = shift_ff;
      ackreq_in = ackreq_ff;
      done      = 1'b0;
      acked     = 1'b0;
      rdata     = 8'd0;
      status    = i2cmbs_pkg::STATUS_OK;
      m         = NB'(1) << bus_ff;

      case (cmd)
         i2cmbs_pkg::CMD_INIT, i2cmbs_pkg::CMD_START, i2cmbs_pkg::CMD_STOP,
         i2cmbs_pkg::CMD_WRITE, i2cmbs_pkg::CMD_READ: begin
            if (busy) begin
               status = i2cmbs_pkg::STATUS_REJECTED;
            end else begin
               m         = NB'(1) << req_bus;
               active_in = cmd;
               bus_in    = req_bus;
               step_in   = 5'd0;
               shift_in  = 8'd0;
               ackreq_in = req_ack;
               case (cmd)
                  i2cmbs_pkg::CMD_INIT: begin
                     scl_in  = scl_ff | m;
                     pull_in = pull_ff & ~m;
                  end
                  i2cmbs_pkg::CMD_START: scl_in = scl_ff | m;
                  i2cmbs_pkg::CMD_WRITE: begin
                     shift_in = req_wdata;
                     scl_in   = scl_ff & ~m;
                     pull_in  = req_wdata[7] ? (pull_ff & ~m) : (pull_ff | m);
                  end
                  default: scl_in = scl_ff & ~m;
               endcase
            end
         end
         i2cmbs_pkg::CMD_TICK: begin
            if (busy) begin
               step_in = t;
               case (active_ff)
                  i2cmbs_pkg::CMD_INIT: begin
                     if (t >= 5'd2 && !req_sda) status = i2cmbs_pkg::STATUS_STUCK;
                  end
                  i2cmbs_pkg::CMD_START: begin
                     if (t == 5'd1) pull_in = pull_ff | m;
                  end
                  i2cmbs_pkg::CMD_STOP: begin
                     if (t == 5'd1) begin
                        pull_in = pull_ff | m;
                        scl_in  = scl_ff | m;
                     end else if (t == 5'd2) begin
                        pull_in = pull_ff & ~m;
                     end
                  end
                  i2cmbs_pkg::CMD_WRITE: begin
                     if (t <= 5'd15 && t[0]) begin
                        scl_in = scl_ff | m;
                     end else if (t <= 5'd14) begin
                        // next data bit; t/2 runs 1..7, so bit index is ~t[3:1]
                        scl_in  = scl_ff & ~m;
                        pull_in = shift_ff[~t[3:1]] ? (pull_ff & ~m) : (pull_ff | m);
                     end else if (t == 5'd16) begin
                        scl_in = scl_ff & ~m;
                     end else if (t == 5'd17) begin
                        pull_in = pull_ff & ~m;
                        scl_in  = scl_ff | m;
                     end else begin
                        acked = !req_sda;
                     end
                  end
                  default: begin
                     if (t == 5'd1) begin
                        pull_in = pull_ff & ~m;
                     end else if (t <= 5'd17 && t[0]) begin
                        shift_in = {shift_ff[6:0], req_sda};
                        scl_in   = scl_ff & ~m;
                        if (t == 5'd17)
                           pull_in = ackreq_ff ? (pull_ff | m) : (pull_ff & ~m);
                     end else if (t <= 5'd18) begin
                        scl_in = scl_ff | m;
                     end else begin
                        rdata = shift_ff;
                     end
                  end
               endcase
               if (t >= total) begin
                  done      = 1'b1;
                  active_in = i2cmbs_pkg::CMD_IDLE;
                  step_in   = 5'd0;
               end
            end
         end
         default: ;
      endcase

      res.scl_lines = scl_in;
      res.sda_pulls = pull_in;
      res.busy_res  = active_in != i2cmbs_pkg::CMD_IDLE;
      res.done_res  = done;
      res.read_data = rdata;
      res.acked     = acked;
      res.status    = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scl_ff    <= '1;
         pull_ff   <= '0;
         active_ff <= i2cmbs_pkg::CMD_IDLE;
         bus_ff    <= 1'b0;
         step_ff   <= 5'd0;
         shift_ff  <= 8'd0;
         ackreq_ff <= 1'b0;
      end else if (accept) begin
         scl_ff    <= scl_in;
         pull_ff   <= pull_in;
         active_ff <= active_in;
         bus_ff    <= bus_in;
         step_ff   <= step_in;
         shift_ff  <= shift_in;
         ackreq_ff <= ackreq_in;
      end
   end

   // output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) out_valid_ff <= 1'b1;
         else skid_valid_ff <= 1'b1;
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) out_ff <= skid_ff;
      end else if (accept) begin
         if (!out_valid_ff || pop) out_ff <= res;
         else skid_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_ff};

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a result while the output register is empty");

   a_idle_step_zero: assert property (@(posedge clock) disable iff (reset)
      !busy |-> step_ff == 5'd0)
      else $error("step count nonzero while idle");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_ff < i2cmbs_pkg::TICKS_READ)
      else $error("step count ran past the longest command");

   a_reject_keeps: assert property (@(posedge clock) disable iff (reset)
      accept && busy && req_tuser <= i2cmbs_pkg::CMD_READ |=>
         $stable(active_ff) && $stable(step_ff))
      else $error("rejected command changed sequencer state");
`endif

endmodule

`default_nettype wire
